// ----- design/gpe_pkg.sv -----
`timescale 1ns / 1ps
package gpe_pkg;

   // Field width and the low terms of the modulus x^64 + x^4 + x^3 + x + 1
   localparam int unsigned GF_WIDTH  = 64;
   localparam int unsigned MOD_LOW_W = 5;
   localparam logic [MOD_LOW_W-1:0] MOD_LOW_TERMS = 5'h1B;

   // Register map: one 64-bit register at byte address 8*i
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [0:0] REG_HASH_KEY = 1'b0;

   typedef logic [GF_WIDTH-1:0] gf_elem_type;

   // Key register contents and the write strobe seen by the datapath
   typedef struct packed {
      logic        key_write;
      gf_elem_type key_wdata;
      gf_elem_type key;
   } csr_ctrl_type;

endpackage

// ----- design/gf2_64_poly_eval_hash_unit.sv -----
`timescale 1ns / 1ps
// Polynomial-evaluation hash over GF(2^64), modulus x^64 + x^4 + x^3 + x + 1.
// Input channel (req_): one 64-bit message block per transfer, with
// req_last_block marking the final block of a message. Result channel (rsp_):
// one hash transfer per message, M(K)*K, issued for the last block only.
// Key register hash_key sits at byte address 0 of the APB-style port; writing
// it restarts the message in progress (sum cleared, key power set to the key).
// Order: a taken block is held in the input register and is folded into the
// running sum when it moves on; for a last block rsp_valid rises at that same edge.
// Throughput: one block per cycle unless a last block waits on a stalled result,
// set by the combinational pair of GF(2^64) multipliers (block times key power,
// key power times key) in the feedback. Reset clears the key, the running sum,
// the key power and both valid flags. When the receiver stalls, the held result
// waits in the output register; non-last blocks keep flowing, and a further last
// block waits in the input register, which then drops req_ready until the result is taken.
module gf2_64_poly_eval_hash_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gpe_pkg::GF_WIDTH-1:0]     req_block_data,
   input  logic                             req_last_block,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gpe_pkg::GF_WIDTH-1:0]     rsp_hash_value,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gpe_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gpe_pkg::GF_WIDTH-1:0]     pwdata,
   output logic [gpe_pkg::GF_WIDTH-1:0]     prdata,
   output logic                             pready
);
   import gpe_pkg::*;

   csr_ctrl_type ctrl;

   logic        s1_valid_ff, s1_valid_in;
   gf_elem_type s1_block_ff, s1_block_in;
   logic        s1_last_ff,  s1_last_in;
   gf_elem_type sum_ff,      sum_in;
   gf_elem_type power_ff,    power_in;
   logic        rsp_valid_ff, rsp_valid_in;
   gf_elem_type hash_ff,     hash_in;

   gf_elem_type term;
   gf_elem_type power_next;
   gf_elem_type sum_next;
   logic        advance;

   gpe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .ctrl    (ctrl)
   );

   gpe_gf_mul u_mul_term (
      .op_a    (s1_block_ff),
      .op_b    (power_ff),
      .product (term)
   );

   gpe_gf_mul u_mul_power (
      .op_a    (power_ff),
      .op_b    (ctrl.key),
      .product (power_next)
   );

   assign sum_next = sum_ff ^ term;

   // A held block moves on unless it is a last block facing a stalled result
   assign advance   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_block_in = s1_block_ff;
      s1_last_in  = s1_last_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_block_in = req_block_data;
         s1_last_in  = req_last_block;
      end
   end

   // Accumulators: key write restarts, last block restarts
   always_comb begin
      sum_in   = sum_ff;
      power_in = power_ff;
      if (ctrl.key_write) begin
         sum_in   = '0;
         power_in = ctrl.key_wdata;
      end else if (advance) begin
         if (s1_last_ff) begin
            sum_in   = '0;
            power_in = ctrl.key;
         end else begin
            sum_in   = sum_next;
            power_in = power_next;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hash_in      = hash_ff;
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         hash_in      = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         power_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         power_ff     <= power_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_block_ff <= s1_block_in;
      s1_last_ff  <= s1_last_in;
      hash_ff     <= hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

   // A key write leaves a fresh message: empty sum, power equal to the key
   a_key_restart: assert property (@(posedge clock) disable iff (reset)
      ctrl.key_write |=> (sum_ff == '0) && (power_ff == ctrl.key))
      else $error("key write did not restart the accumulators");

   // A last block yields a result and restarts the accumulators
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> rsp_valid_ff && (sum_ff == '0) && (power_ff == ctrl.key))
      else $error("last block did not issue a result and restart");

   // Back-pressure only from a last block blocked by a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked last block");

   // A stalled result is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(hash_ff))
      else $error("stalled result lost or changed");

endmodule

// ----- design/gpe_gf_mul.sv -----
`timescale 1ns / 1ps
module gpe_gf_mul (
   input  gpe_pkg::gf_elem_type op_a,
   input  gpe_pkg::gf_elem_type op_b,
   output gpe_pkg::gf_elem_type product
);
   import gpe_pkg::*;

   logic [2*GF_WIDTH-1:0]         clmul;
   logic [GF_WIDTH+MOD_LOW_W-2:0] fold;
   logic [MOD_LOW_W-2:0]          over;
   gf_elem_type                   fold_low;
   gf_elem_type                   over_fold;

   // Carry-less product: XOR of independent shifted partial products
   always_comb begin
      clmul = '0;
      for (int j = 0; j < GF_WIDTH; j++) begin
         if (op_b[j]) begin
            clmul = clmul ^ ({{GF_WIDTH{1'b0}}, op_a} << j);
         end
      end
   end

   // First fold: high half times the low terms of the modulus
   always_comb begin
      fold = '0;
      for (int k = 0; k < MOD_LOW_W; k++) begin
         if (MOD_LOW_TERMS[k]) begin
            fold = fold ^ ({{(MOD_LOW_W-1){1'b0}}, clmul[2*GF_WIDTH-1:GF_WIDTH]} << k);
         end
      end
   end

   // Second fold: the few bits that spilled above x^63 again
   always_comb begin
      over      = fold[GF_WIDTH+MOD_LOW_W-2:GF_WIDTH];
      fold_low  = fold[GF_WIDTH-1:0];
      over_fold = '0;
      for (int k = 0; k < MOD_LOW_W; k++) begin
         if (MOD_LOW_TERMS[k]) begin
            over_fold = over_fold ^ ({{(GF_WIDTH-MOD_LOW_W+1){1'b0}}, over} << k);
         end
      end
   end

   assign product = clmul[GF_WIDTH-1:0] ^ fold_low ^ over_fold;

endmodule

// ----- design/gpe_csr.sv -----
`timescale 1ns / 1ps
module gpe_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gpe_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gpe_pkg::GF_WIDTH-1:0]     pwdata,
   output logic [gpe_pkg::GF_WIDTH-1:0]     prdata,
   output logic                             pready,
   output gpe_pkg::csr_ctrl_type            ctrl
);
   import gpe_pkg::*;

   gf_elem_type key_ff;
   gf_elem_type key_in;
   logic        sel_key;
   logic        key_write;

   // Register decode on the index bit of the byte address
   assign sel_key   = (paddr[CSR_ADDR_W-1:CSR_ADDR_W-1] == REG_HASH_KEY);
   assign key_write = psel && penable && pwrite && sel_key;

   always_comb begin
      key_in = key_ff;
      if (key_write) begin
         key_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = sel_key ? key_ff : '0;

   assign ctrl.key_write = key_write;
   assign ctrl.key_wdata = pwdata;
   assign ctrl.key       = key_ff;

endmodule
